>>> hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the bit store.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define BASS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bit store assertion failed");

// Clocked assertion that also holds through reset.
`define BASS_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bit store assertion failed");

`endif

>>> hw/rtl/bass_pkg.sv
// Shared types and constants for the bit-addressable stream store.
// Used by the field merge unit and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bass_pkg;

  // Default store size in bytes.
  localparam int DEFAULT_STORE_BYTES = 4096;

  // Bit offset inside a byte.
  localparam logic [2:0] BIT_OFF_MASK = 3'b111;

  // Largest number of bits that one access moves.
  localparam logic [3:0] MAX_COUNT = 4'd8;

  // Operation codes carried in the input tuser.
  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_SET   = 3'd2,
    OP_INC   = 3'd3,
    OP_DEC   = 3'd4
  } op_t;

  // Field description handed to the merge unit.
  typedef struct packed {
    logic [2:0] off;
    logic [3:0] count;
    logic [7:0] wdata;
  } field_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/bass_bank_ram.sv
// One byte-wide bank of the store: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bass_bank_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/bass_field.sv
// Extracts and merges a field of up to eight bits in a pair of adjacent bytes.
// Depends on bass_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bass_field (
  input  wire logic [7:0]          lo,
  input  wire logic [7:0]          hi,
  input  wire bass_pkg::field_ctrl_t ctrl,
  output logic [7:0]               rd_bits,
  output logic [7:0]               new_lo,
  output logic [7:0]               new_hi
);
  import bass_pkg::*;

  logic [15:0] word;
  logic [15:0] mask;
  logic [15:0] field_mask;
  logic [15:0] shifted;
  logic [15:0] merged;

  // Build the mask of count bits and place it at the bit offset.
  always_comb begin
    word       = {hi, lo};
    mask       = (16'd1 << ctrl.count) - 16'd1;
    field_mask = mask << (ctrl.off & BIT_OFF_MASK);
    shifted    = word >> ctrl.off;
    merged     = (word & ~field_mask) | (({8'd0, ctrl.wdata} & mask) << ctrl.off);
  end

  assign rd_bits = shifted[7:0] & mask[7:0];
  assign new_lo  = merged[7:0];
  assign new_hi  = merged[15:8];

endmodule

`default_nettype wire

>>> hw/rtl/bit_addressable_stream_store_core.sv
// Channel  | Beat contents (low bit first)                           | Direction
// in_      | tuser: operation[2:0], at_pointer[3]                    | in
//          | tdata: bit_address[14:0], bit_count[18:15],             |
//          |        write_data[26:19], pointer_step[42:27]           |
// out_     | tuser: out_of_range[0]                                  | out
//          | tdata: read_data[7:0], pointer_now[23:8]                |
// Each item is handled in order: the accept edge reads both byte banks, and the write-back
// state then writes the merged bytes back and loads the result register.
// After reset a clearing pass zeroes the store, one row of both banks a cycle;
// in_tready stays low until it is done.
// A stalled result holds the block in its write-back cycle; no new beat is taken.
// Depends on bass_pkg, bass_bank_ram and bass_field.
`timescale 1ns / 1ps
`default_nettype none

module bit_addressable_stream_store_core #(
  parameter int STORE_BYTES = bass_pkg::DEFAULT_STORE_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // bit_address, bit_count, write_data, pointer_step
  input  wire logic [3:0]  in_tuser,   // operation, at_pointer
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // read_data, pointer_now
  output logic             out_tuser   // out_of_range
);
  import bass_pkg::*;

  localparam int CAP_BITS = STORE_BYTES * 8;
  localparam int PW       = $clog2(CAP_BITS + 1);
  localparam int SW       = (PW > 15) ? PW : 15;
  localparam int IW       = ((PW > 16) ? PW : 16) + 1;
  localparam int BW       = SW - 3;
  localparam int DEPTH    = (STORE_BYTES + 1) / 2;
  localparam int RW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [SW:0]   CAP_S     = (SW + 1)'(CAP_BITS);
  localparam logic [IW-1:0] CAP_I     = IW'(CAP_BITS);
  localparam logic [BW:0]   BYTES_B   = (BW + 1)'(STORE_BYTES);
  localparam logic [RW-1:0] LAST_ROW  = RW'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_ACCESS = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Input beat fields.
  op_t        op;
  logic       at_ptr;
  logic [14:0] addr;
  logic [3:0]  cnt_in;
  logic [7:0]  wdat;
  logic [15:0] step;
  logic [3:0]  cnt_sat;
  logic        in_fire;

  // Address arithmetic for the access.
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [SW-1:0] start;
  logic [SW:0]   end_pos;
  logic [SW:0]   addr_ext;
  logic [IW-1:0] inc_sum;
  logic [IW-1:0] dec_diff;
  logic          is_access;
  logic          range_err;
  logic [BW-1:0] first_byte;
  logic [BW:0]   bidx_p1;
  logic          hi_ok;
  logic [BW-2:0] odd_row_w;
  logic [BW-1:0] even_row_w;

  // Item held during write-back.
  logic          bsel_r;
  logic          hi_en_r;
  logic          wr_en_r;
  logic          rd_keep_r;
  logic          err_r;
  field_ctrl_t   ctrl_r;
  logic [RW-1:0] even_row_r;
  logic [RW-1:0] odd_row_r;

  // Clearing pass.
  logic [RW-1:0] clr_cnt_r;

  // Bank ports.
  logic          ev_we, od_we;
  logic [RW-1:0] ev_waddr, od_waddr;
  logic [7:0]    ev_wdata, od_wdata;
  logic [7:0]    ev_rd, od_rd;
  logic [7:0]    lo_byte, hi_byte;
  logic [7:0]    rd_bits, new_lo, new_hi;

  // Result register.
  logic          advance;
  logic          out_valid_r;
  logic [7:0]    out_rdata_r;
  logic [15:0]   out_ptr_r;
  logic          out_err_r;
  logic [PW+15:0] ptr_ext;

  // Unpack the input beat.
  always_comb begin
    op      = op_t'(in_tuser[2:0]);
    at_ptr  = in_tuser[3];
    addr    = in_tdata[14:0];
    cnt_in  = in_tdata[18:15];
    wdat    = in_tdata[26:19];
    step    = in_tdata[42:27];
    cnt_sat = (cnt_in > MAX_COUNT) ? MAX_COUNT : cnt_in;
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Start position, end check and the pair of byte rows to read.
  always_comb begin
    start      = at_ptr ? SW'(ptr_r) : SW'(addr);
    end_pos    = {1'b0, start} + (SW + 1)'(cnt_sat);
    is_access  = (op == OP_READ) || (op == OP_WRITE);
    range_err  = is_access && (end_pos > CAP_S);
    first_byte = start[SW-1:3];
    bidx_p1    = {1'b0, first_byte} + (BW + 1)'(1);
    hi_ok      = bidx_p1 < BYTES_B;
    odd_row_w  = first_byte[BW-1:1];
    even_row_w = bidx_p1[BW:1];
  end

  // Pointer update; it does not depend on the store, so it settles at accept.
  always_comb begin
    addr_ext = (SW + 1)'(addr);
    inc_sum  = IW'(ptr_r) + IW'(step);
    dec_diff = IW'(ptr_r) - IW'(step);
    ptr_nxt  = ptr_r;
    unique case (op)
      OP_WRITE: begin
        if (at_ptr && !range_err && (cnt_sat != 4'd0)) begin
          ptr_nxt = PW'(end_pos);
        end
      end
      OP_SET: begin
        ptr_nxt = (addr_ext > CAP_S) ? PW'(CAP_S) : PW'(addr_ext);
      end
      OP_INC: begin
        ptr_nxt = (inc_sum > CAP_I) ? PW'(CAP_I) : PW'(inc_sum);
      end
      OP_DEC: begin
        ptr_nxt = (IW'(step) > IW'(ptr_r)) ? '0 : PW'(dec_diff);
      end
      default: begin
        ptr_nxt = ptr_r;
      end
    endcase
  end

  // Sequencer: clearing pass, idle, then a write-back state for each item.
  assign advance = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        if (advance) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      ptr_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + RW'(1);
      end
      if (in_fire) begin
        ptr_r <= ptr_nxt;
      end
    end
  end

  // Hold what the write-back cycle needs.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bsel_r       <= first_byte[0];
      hi_en_r      <= hi_ok;
      wr_en_r      <= (op == OP_WRITE) && !range_err && (cnt_sat != 4'd0);
      rd_keep_r    <= (op == OP_READ) && !range_err;
      err_r        <= range_err;
      ctrl_r.off   <= start[2:0] & BIT_OFF_MASK;
      ctrl_r.count <= cnt_sat;
      ctrl_r.wdata <= wdat;
      even_row_r   <= even_row_w[RW-1:0];
      odd_row_r    <= odd_row_w[RW-1:0];
    end
  end

  // Route the two banks to the low and high byte of the pair.
  always_comb begin
    lo_byte = bsel_r ? od_rd : ev_rd;
    hi_byte = hi_en_r ? (bsel_r ? ev_rd : od_rd) : 8'd0;
  end

  bass_field u_field (
    .lo      (lo_byte),
    .hi      (hi_byte),
    .ctrl    (ctrl_r),
    .rd_bits (rd_bits),
    .new_lo  (new_lo),
    .new_hi  (new_hi)
  );

  // Bank write ports: clearing pass or write-back of the merged pair.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ev_we    = 1'b1;
      od_we    = 1'b1;
      ev_waddr = clr_cnt_r;
      od_waddr = clr_cnt_r;
      ev_wdata = 8'd0;
      od_wdata = 8'd0;
    end else begin
      ev_we    = (state_r == ST_ACCESS) && advance && wr_en_r && (bsel_r ? hi_en_r : 1'b1);
      od_we    = (state_r == ST_ACCESS) && advance && wr_en_r && (bsel_r ? 1'b1 : hi_en_r);
      ev_waddr = even_row_r;
      od_waddr = odd_row_r;
      ev_wdata = bsel_r ? new_hi : new_lo;
      od_wdata = bsel_r ? new_lo : new_hi;
    end
  end

  // Reads are issued only at accept and writes only in the clearing pass and the
  // write-back cycle, so the sequencer keeps accesses to one row from overlapping.
  bass_bank_ram #(.DEPTH(DEPTH), .AW(RW)) u_even (
    .clk   (clk),
    .we    (ev_we),
    .waddr (ev_waddr),
    .wdata (ev_wdata),
    .re    (in_fire),
    .raddr (even_row_w[RW-1:0]),
    .rdata (ev_rd)
  );

  bass_bank_ram #(.DEPTH(DEPTH), .AW(RW)) u_odd (
    .clk   (clk),
    .we    (od_we),
    .waddr (od_waddr),
    .wdata (od_wdata),
    .re    (in_fire),
    .raddr (odd_row_w[RW-1:0]),
    .rdata (od_rd)
  );

  // Result register.
  assign ptr_ext = {16'd0, ptr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_ACCESS) && advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_ACCESS) && advance) begin
      out_rdata_r <= rd_keep_r ? rd_bits : 8'd0;
      out_ptr_r   <= ptr_ext[15:0];
      out_err_r   <= err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ptr_r, out_rdata_r};
  assign out_tuser  = out_err_r;

endmodule

`default_nettype wire

>>> hw/rtl/bass_checker.sv
// Port-level checks for the bit-addressable stream store, bound to the top level.
// Depends on assert_macros.svh and bit_addressable_stream_store_core.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bass_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tuser
);

  // A stalled result beat keeps its contents.
  `BASS_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // The block works on one item at a time.
  `BASS_ASSERT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready |=> !in_tready)

  // An access past the end returns no data.
  `BASS_ASSERT(a_flag_no_data, clk, rst_n, out_tvalid && out_tuser |-> out_tdata[7:0] == 8'd0)

  // Reset starts the clearing pass with both channels quiet.
  `BASS_ASSERT_RST(a_reset_quiet, clk, !rst_n |=> !in_tready && !out_tvalid)

endmodule

bind bit_addressable_stream_store_core bass_checker u_bass_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

>>> dv/bit_store_checker.sv
// Checker for the bit-addressable stream store: watches both channels, predicts
// every result beat from its own copy of the store and pointer, and counts mismatches.
// Depends on bass_pkg for the operation codes and the count limit.
`timescale 1ns / 1ps

module bit_store_checker #(
  parameter int STORE_BYTES = bass_pkg::DEFAULT_STORE_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,     // bit_address, bit_count, write_data, pointer_step
  input  logic [3:0]  in_tuser,     // operation, at_pointer
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,    // read_data, pointer_now
  input  logic        out_tuser,    // out_of_range
  output int          mismatches,
  output int          outstanding
);

  import bass_pkg::*;

  localparam int CAP_BITS     = STORE_BYTES * 8;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] pointer_now;
    logic        out_of_range;
  } access_result_t;

  // Shadow copy of the store and the bit pointer; both start at zero.
  logic [7:0]     shadow_bytes [STORE_BYTES];
  int unsigned    shadow_ptr;
  access_result_t awaited_results [$];
  int             fail_total;

  initial begin
    for (int i = 0; i < STORE_BYTES; i++) begin
      shadow_bytes[i] = 8'h00;
    end
    shadow_ptr = 0;
    fail_total = 0;
  end

  // Applies one input beat to the shadow state and returns the result it causes.
  function automatic access_result_t apply_bit_op(input logic [3:0]  user,
                                                  input logic [47:0] data);
    access_result_t res;
    logic [2:0]     op;
    logic           at_ptr;
    int unsigned    addr;
    int unsigned    count;
    int unsigned    step;
    int unsigned    start;
    int unsigned    first_byte;
    logic [2:0]     off;
    logic [15:0]    word;
    logic [15:0]    mask;
    logic [15:0]    field;
    op     = user[2:0];
    at_ptr = user[3];
    addr   = data[14:0];
    count  = data[18:15];
    step   = data[42:27];
    res    = '0;
    // Counts above eight act as eight.
    if (count > MAX_COUNT) count = MAX_COUNT;
    case (op)
      OP_READ, OP_WRITE: begin
        start = at_ptr ? shadow_ptr : addr;
        if (start + count > CAP_BITS) begin
          // Past the end: nothing moves, only the flag is raised.
          res.out_of_range = 1'b1;
        end else if (count != 0) begin
          first_byte = start >> 3;
          off        = start[2:0];
          mask       = 16'((1 << count) - 1);
          word       = {8'h00, shadow_bytes[first_byte]};
          if (first_byte + 1 < STORE_BYTES) word[15:8] = shadow_bytes[first_byte + 1];
          if (op == OP_READ) begin
            res.read_data = 8'((word >> off) & mask);
          end else begin
            field = mask << off;
            word  = (word & ~field) | ((16'(data[26:19]) & mask) << off);
            shadow_bytes[first_byte] = word[7:0];
            if (first_byte + 1 < STORE_BYTES) shadow_bytes[first_byte + 1] = word[15:8];
            // Of reads and writes, only a write at the pointer advances it.
            if (at_ptr) shadow_ptr = start + count;
          end
        end
      end
      OP_SET: shadow_ptr = (addr > CAP_BITS) ? CAP_BITS : addr;
      OP_INC: shadow_ptr = (shadow_ptr + step > CAP_BITS) ? CAP_BITS : shadow_ptr + step;
      OP_DEC: shadow_ptr = (step > shadow_ptr) ? 0 : shadow_ptr - step;
      default: ;
    endcase
    res.pointer_now = shadow_ptr[15:0];
    return res;
  endfunction

  function automatic void note_mismatch(input string name, input int unsigned want,
                                        input int unsigned got);
    fail_total++;
    $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
  endfunction

  // Result beats are checked before the input beat of the same edge is queued.
  always @(posedge clk) begin
    access_result_t want;
    access_result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.read_data    = out_tdata[7:0];
        got.pointer_now  = out_tdata[23:8];
        got.out_of_range = out_tuser;
        if (awaited_results.size() == 0) begin
          fail_total++;
          $error("result beat with no pending expectation: tdata 0x%0h", out_tdata);
        end else begin
          want = awaited_results.pop_front();
          if (got.read_data != want.read_data) begin
            note_mismatch("read_data", want.read_data, got.read_data);
          end
          if (got.pointer_now != want.pointer_now) begin
            note_mismatch("pointer_now", want.pointer_now, got.pointer_now);
          end
          if (got.out_of_range != want.out_of_range) begin
            note_mismatch("out_of_range", want.out_of_range, got.out_of_range);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(apply_bit_op(in_tuser, in_tdata));
      end
    end
    mismatches  <= fail_total;
    outstanding <= awaited_results.size();
  end

endmodule

>>> dv/bit_addressable_stream_store_core_tb.sv
// Top of the bit store testbench: clock, reset, stimulus and verdict.
// Depends on bass_pkg, the bit_addressable_stream_store_core block and bit_store_checker.
`timescale 1ns / 1ps

module bit_addressable_stream_store_core_tb;

  import bass_pkg::*;

  localparam int STORE_BYTES  = DEFAULT_STORE_BYTES;
  localparam int CAP_BITS     = STORE_BYTES * 8;
  localparam int RANDOM_ITEMS = 2000;
  localparam int IDLE_PCT     = 7;
  localparam int CALM_FROM    = 4500;
  localparam int CALM_TO      = 6000;
  localparam int HOLD_AT      = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 10000;
  localparam int DRAIN_CYCLES = 8;

  // Operation codes that the block treats as no-ops.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_MID   = 3'd6;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic [3:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;

  int mismatches;
  int outstanding;
  int cycle_cnt  = 0;
  int stall_cnt  = 0;
  int items_sent = 0;

  bit_addressable_stream_store_core #(
    .STORE_BYTES(STORE_BYTES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  bit_store_checker #(
    .STORE_BYTES(STORE_BYTES)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("bit_addressable_stream_store_core verification failed");
      $finish;
    end
  end

  // Random idle cycle, except inside the calm window.
  function automatic bit take_break();
    if (cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // Bit position: mostly a small window so reads meet earlier writes, some near the end.
  function automatic int unsigned pick_bit_pos();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80) return $urandom_range(511);
    if (roll < 95) return CAP_BITS - 1 - $urandom_range(40);
    return $urandom_range(CAP_BITS - 1);
  endfunction

  // Offers one beat and returns right after the edge that accepts it.
  task automatic send_item(input logic [2:0] op, input logic at_ptr, input int unsigned addr,
                           input int unsigned count, input int unsigned wdata,
                           input int unsigned step);
    while (take_break()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {at_ptr, op};
    in_tdata  <= {5'd0, 16'(step), 8'(wdata), 4'(count), 15'(addr)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Receiver: random back-pressure plus one long hold-off that fills the block.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (cycle_cnt == HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= !take_break();
      @(posedge clk);
    end
  end

  // Sender: directed corner cases, then random traffic, then drain and verdict.
  initial begin
    int unsigned roll;
    int unsigned base;
    int unsigned run_len;
    int unsigned run_counts [8];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Cleared store, a write that spans two bytes, its read-back, and an over-long count.
    send_item(OP_READ,  1'b0, 0, 8, 8'h00, 0);
    send_item(OP_WRITE, 1'b0, 5, 8, 8'hA5, 0);
    send_item(OP_READ,  1'b0, 5, 8, 8'h00, 0);
    send_item(OP_READ,  1'b0, 0, 15, 8'hFF, 16'hFFFF);
    // Last bit of the store, and an access that passes the end.
    send_item(OP_WRITE, 1'b0, CAP_BITS - 1, 1, 8'hFF, 0);
    send_item(OP_READ,  1'b0, CAP_BITS - 8, 8, 8'h00, 0);
    send_item(OP_WRITE, 1'b0, CAP_BITS - 1, 2, 8'hFF, 0);
    send_item(OP_READ,  1'b0, CAP_BITS - 1, 0, 8'h00, 0);
    // A zero-count write changes nothing.
    send_item(OP_WRITE, 1'b0, 3, 0, 8'hFF, 0);
    // Pointer saturation at the capacity and at zero.
    send_item(OP_SET,   1'b1, CAP_BITS - 1, 15, 8'hFF, 16'hFFFF);
    send_item(OP_INC,   1'b1, 15'h7FFF, 15, 8'hFF, 16'hFFFF);
    send_item(OP_WRITE, 1'b1, 0, 1, 8'hFF, 0);
    send_item(OP_READ,  1'b1, 0, 0, 8'h00, 0);
    send_item(OP_DEC,   1'b0, 0, 0, 8'h00, 1);
    send_item(OP_WRITE, 1'b1, 0, 1, 8'h00, 0);
    send_item(OP_DEC,   1'b1, 15'h7FFF, 15, 8'hFF, 16'hFFFF);
    // Writes at the pointer advance it; a read at the pointer leaves it.
    send_item(OP_WRITE, 1'b1, 15'h7FFF, 12, 8'h3C, 0);
    send_item(OP_WRITE, 1'b1, 15'h7FFF, 7, 8'h7F, 0);
    send_item(OP_READ,  1'b1, 0, 8, 8'h00, 0);
    send_item(OP_READ,  1'b0, 0, 8, 8'h00, 0);
    // Spare codes do nothing.
    send_item(OP_SPARE_FIRST, 1'b1, 15'h7FFF, 8, 8'hFF, 16'hFFFF);
    send_item(OP_SPARE_MID,   1'b0, 0, 0, 8'h00, 0);
    send_item(OP_SPARE_LAST,  1'b1, 100, 4, 8'h5A, 16'h8000);
    send_item(OP_INC,   1'b0, 0, 0, 8'h00, 0);
    send_item(OP_SET,   1'b0, 0, 0, 8'h00, 0);
    send_item(OP_INC,   1'b0, 0, 0, 8'h00, 16'h8000);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 20) begin
        // Streaming run: write fields at the pointer, rewind, read them back in order.
        base    = pick_bit_pos();
        run_len = $urandom_range(1, 8);
        send_item(OP_SET, $urandom_range(1), base, $urandom_range(15), $urandom, $urandom);
        for (int k = 0; k < run_len; k++) begin
          run_counts[k] = $urandom_range(1, 8);
          send_item(OP_WRITE, 1'b1, $urandom, run_counts[k], $urandom, $urandom);
        end
        send_item(OP_SET, $urandom_range(1), base, $urandom_range(15), $urandom, $urandom);
        for (int k = 0; k < run_len; k++) begin
          send_item(OP_READ, 1'b1, $urandom, run_counts[k], $urandom, $urandom);
          send_item(OP_INC, $urandom_range(1), $urandom, $urandom_range(15), $urandom,
                    run_counts[k]);
        end
      end else if (roll < 55) begin
        send_item(OP_WRITE, $urandom_range(99) < 25, pick_bit_pos(), $urandom_range(1, 8),
                  $urandom, $urandom);
      end else if (roll < 80) begin
        send_item(OP_READ, $urandom_range(99) < 25, pick_bit_pos(), $urandom_range(1, 8),
                  $urandom, $urandom);
      end else if (roll < 92) begin
        // Pointer moves: mostly short steps, sometimes any 16-bit step.
        case ($urandom_range(2))
          0: send_item(OP_SET, $urandom_range(1), pick_bit_pos(), $urandom_range(15),
                       $urandom, $urandom);
          1: send_item(OP_INC, $urandom_range(1), $urandom, $urandom_range(15), $urandom,
                       ($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
                                                : $urandom_range(64));
          default: send_item(OP_DEC, $urandom_range(1), $urandom, $urandom_range(15),
                             $urandom, ($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
                                                                : $urandom_range(64));
        endcase
      end else begin
        // Noise: every field at random, spare codes and odd counts included.
        send_item($urandom_range(7), $urandom_range(1), $urandom_range(CAP_BITS - 1),
                  $urandom_range(15), $urandom, $urandom_range(16'hFFFF));
      end
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every expected result, then let the channels settle before the verdict.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("bit_addressable_stream_store_core verification clean");
    end else begin
      $display("bit_addressable_stream_store_core verification failed");
    end
    $finish;
  end

endmodule
